@@ hw/rtl/fs4dc_pkg.sv @@
// Shared types and constants for the fs/4 down-converter and half-band decimator.
package fs4dc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int FRAC_BITS = 15;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // Item command codes
    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_LOAD   = 1'b1
    } cmd_t;

    // Sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE = 2'd0,
        ST_ROT  = 2'd1,
        ST_FIN  = 2'd2,
        ST_OUT  = 2'd3
    } state_t;

    // Control shared by every cell of the chain
    typedef struct packed
    {
        logic shift;   // new sample enters at the top, all others move down
        logic rotate;  // samples and taps circulate one place
    } cell_ctrl_t;

    // Mixer negate with saturation of the most negative value
    function automatic logic signed [SAMPLE_W-1:0] neg_sat(input logic signed [SAMPLE_W-1:0] x);
        logic signed [SAMPLE_W-1:0] r;
        if (x == SAT_MIN)
        begin
            r = SAT_MAX;
        end
        else
        begin
            r = -x;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/fs4dc_cell.sv @@
// One window cell: holds a complex sample and a tap, passes both to its neighbor.
module fs4dc_cell
    import fs4dc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic                       tap_we,
    input  logic signed [COEF_W-1:0]   tap_wdata,
    input  logic signed [SAMPLE_W-1:0] nbr_i,
    input  logic signed [SAMPLE_W-1:0] nbr_q,
    input  logic signed [COEF_W-1:0]   nbr_tap,
    output logic signed [SAMPLE_W-1:0] cell_i,
    output logic signed [SAMPLE_W-1:0] cell_q,
    output logic signed [COEF_W-1:0]   cell_tap
);

    logic signed [SAMPLE_W-1:0] smp_i_reg, smp_i_next;
    logic signed [SAMPLE_W-1:0] smp_q_reg, smp_q_next;
    logic signed [COEF_W-1:0]   tap_reg,   tap_next;

    // Next-value selection
    always_comb
    begin
        smp_i_next = smp_i_reg;
        smp_q_next = smp_q_reg;
        tap_next   = tap_reg;
        if (ctrl.shift || ctrl.rotate)
        begin
            smp_i_next = nbr_i;
            smp_q_next = nbr_q;
        end
        if (ctrl.rotate)
        begin
            tap_next = nbr_tap;
        end
        else if (tap_we)
        begin
            tap_next = tap_wdata;
        end
    end

    // Cell storage, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_i_reg <= '0;
            smp_q_reg <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            smp_i_reg <= smp_i_next;
            smp_q_reg <= smp_q_next;
            tap_reg   <= tap_next;
        end
    end

    assign cell_i   = smp_i_reg;
    assign cell_q   = smp_q_reg;
    assign cell_tap = tap_reg;

endmodule

@@ hw/rtl/fs4dc_mac.sv @@
// Shared I/Q multiply-accumulate at the chain head, with Q15 shift and saturation.
module fs4dc_mac
    import fs4dc_pkg::*;
#(
    parameter int SUM_W = 38
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       en,
    input  logic signed [COEF_W-1:0]   tap,
    input  logic signed [SAMPLE_W-1:0] s_i,
    input  logic signed [SAMPLE_W-1:0] s_q,
    output logic signed [SAMPLE_W-1:0] res_i,
    output logic signed [SAMPLE_W-1:0] res_q
);

    localparam logic signed [SUM_W-1:0] HI = SUM_W'(SAT_MAX);
    localparam logic signed [SUM_W-1:0] LO = SUM_W'(SAT_MIN);

    logic signed [PROD_W-1:0] prod_i_reg, prod_q_reg;
    logic                     pv_reg;
    logic signed [SUM_W-1:0]  acc_i_reg, acc_i_next;
    logic signed [SUM_W-1:0]  acc_q_reg, acc_q_next;
    logic signed [SUM_W-1:0]  shr_i, shr_q;

    // Product stage
    always_ff @(posedge clk)
    begin
        prod_i_reg <= s_i * tap;
        prod_q_reg <= s_q * tap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= en;
        end
    end

    // Accumulate stage
    always_comb
    begin
        acc_i_next = acc_i_reg;
        acc_q_next = acc_q_reg;
        if (clear)
        begin
            acc_i_next = '0;
            acc_q_next = '0;
        end
        else if (pv_reg)
        begin
            acc_i_next = acc_i_reg + SUM_W'(prod_i_reg);
            acc_q_next = acc_q_reg + SUM_W'(prod_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_i_reg <= acc_i_next;
        acc_q_reg <= acc_q_next;
    end

    // Floor shift by the Q15 point, then clamp to 16 bits
    assign shr_i = acc_i_reg >>> FRAC_BITS;
    assign shr_q = acc_q_reg >>> FRAC_BITS;

    always_comb
    begin
        if (shr_i > HI)
        begin
            res_i = SAT_MAX;
        end
        else if (shr_i < LO)
        begin
            res_i = SAT_MIN;
        end
        else
        begin
            res_i = shr_i[SAMPLE_W-1:0];
        end

        if (shr_q > HI)
        begin
            res_q = SAT_MAX;
        end
        else if (shr_q < LO)
        begin
            res_q = SAT_MIN;
        end
        else
        begin
            res_q = shr_q[SAMPLE_W-1:0];
        end
    end

endmodule

@@ hw/rtl/fs4_downconvert_halfband_decimate_unit.sv @@
// fs/4 mixer with NTAPS-tap FIR decimate-by-two, built as a rotating chain of cells.
// Tap loads and odd samples are taken in idle; an unread result holds back the next emit.
// An even sample circulates the window once past one I/Q multiplier in the rotate state,
// then passes the product and accumulate stages; the output state holds the result beat
// until the output register is free, and input reopens only once back in idle.
// Reset (async, active low) clears phase, toggle, window and taps; first sample emits.
module fs4_downconvert_halfband_decimate_unit
    import fs4dc_pkg::*;
#(
    parameter int NTAPS = 39
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic        [5:0]          tap_index,
    input  logic signed [COEF_W-1:0]   tap_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_i,
    output logic signed [SAMPLE_W-1:0] out_q
);

    localparam int SUM_W = PROD_W + $clog2(NTAPS);
    localparam int CNT_W = $clog2(NTAPS);

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [1:0]                 phase_reg, phase_next;
    logic                       toggle_reg, toggle_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_i_reg, out_i_next;
    logic signed [SAMPLE_W-1:0] out_q_reg, out_q_next;

    logic                       acc_clear;
    logic                       mac_en;
    logic                       in_beat;
    logic                       smp_beat;
    logic                       load_beat;
    cell_ctrl_t                 ctrl;
    logic signed [SAMPLE_W-1:0] mix_i, mix_q;
    logic signed [SAMPLE_W-1:0] res_i, res_q;

    logic signed [SAMPLE_W-1:0] ci [NTAPS];
    logic signed [SAMPLE_W-1:0] cq [NTAPS];
    logic signed [COEF_W-1:0]   ct [NTAPS];
    logic signed [SAMPLE_W-1:0] ni [NTAPS];
    logic signed [SAMPLE_W-1:0] nq [NTAPS];
    logic signed [COEF_W-1:0]   nt [NTAPS];
    logic [NTAPS-1:0]           tap_we;

    assign in_beat   = in_valid && in_ready;
    assign smp_beat  = in_beat && (cmd_t'(command) == CMD_SAMPLE);
    assign load_beat = in_beat && (cmd_t'(command) == CMD_LOAD);

    // fs/4 mixer: (x,0), (0,-x), (-x,0), (0,x)
    always_comb
    begin
        mix_i = '0;
        mix_q = '0;
        case (phase_reg)
            2'd0:    mix_i = sample;
            2'd1:    mix_q = neg_sat(sample);
            2'd2:    mix_i = neg_sat(sample);
            2'd3:    mix_q = sample;
            default: mix_i = '0;
        endcase
    end

    // Cell chain: each cell takes its upper neighbor; the top takes the new sample or wraps
    generate
        for (genvar j = 0; j < NTAPS; j++)
        begin : g_cell
            if (j == NTAPS - 1)
            begin : g_top
                assign ni[j] = ctrl.shift ? mix_i : ci[0];
                assign nq[j] = ctrl.shift ? mix_q : cq[0];
                assign nt[j] = ct[0];
            end
            else
            begin : g_mid
                assign ni[j] = ci[j+1];
                assign nq[j] = cq[j+1];
                assign nt[j] = ct[j+1];
            end

            assign tap_we[j] = load_beat && (32'(tap_index) == 32'(j));

            fs4dc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .tap_we    (tap_we[j]),
                .tap_wdata (tap_value),
                .nbr_i     (ni[j]),
                .nbr_q     (nq[j]),
                .nbr_tap   (nt[j]),
                .cell_i    (ci[j]),
                .cell_q    (cq[j]),
                .cell_tap  (ct[j])
            );
        end
    endgenerate

    // MAC on the chain head
    fs4dc_mac #(
        .SUM_W (SUM_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (acc_clear),
        .en    (mac_en),
        .tap   (ct[0]),
        .s_i   (ci[0]),
        .s_q   (cq[0]),
        .res_i (res_i),
        .res_q (res_q)
    );

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        toggle_next    = toggle_reg;
        out_valid_next = out_valid_reg;
        out_i_next     = out_i_reg;
        out_q_next     = out_q_reg;
        in_ready       = 1'b0;
        acc_clear      = 1'b0;
        mac_en         = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.rotate    = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (smp_beat)
                begin
                    ctrl.shift  = 1'b1;
                    phase_next  = phase_reg + 2'd1;
                    toggle_next = ~toggle_reg;
                    if (!toggle_reg)
                    begin
                        acc_clear  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_ROT;
                    end
                end
            end
            ST_ROT:
            begin
                ctrl.rotate = 1'b1;
                mac_en      = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NTAPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_i_next     = res_i;
                    out_q_next     = res_q;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            toggle_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            toggle_reg    <= toggle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_i_reg <= out_i_next;
        out_q_reg <= out_q_next;
    end

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

endmodule
